// ===== sv/image_format_sniffer_core_macros.svh =====
// Assertion macros for the image format sniffer.
// Used by the top level; clk and rst_n must be in scope where a macro is used.
`ifndef IMAGE_FORMAT_SNIFFER_CORE_MACROS_SVH
`define IMAGE_FORMAT_SNIFFER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property outside reset.
`define IFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define IFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFS_ASSERT(lbl, prop, msg)
`define IFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/ifs_pkg.sv =====
// Shared constants, tag strings and types of the image format sniffer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package ifs_pkg;

  localparam int HEADER_BYTES = 2048;
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);
  localparam int HEAD_LEN     = 7;
  localparam int REC_LEN      = 11;
  localparam int PIC_LEN      = 8;

  localparam logic [7:0] REC_TAG [REC_LEN] = '{
    8'h52, 8'h45, 8'h43, 8'h4f, 8'h52, 8'h44, 8'h5f, 8'h54, 8'h59, 8'h50, 8'h45
  };
  localparam logic [7:0] PIC_TAG [PIC_LEN] = '{
    8'h50, 8'h69, 8'h63, 8'h64, 8'h61, 8'h74, 8'h61, 8'h3a
  };

  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam logic [3:0] FMT_TIFF    = 4'd0;
  localparam logic [3:0] FMT_PICFILE = 4'd1;
  localparam logic [3:0] FMT_XBM     = 4'd2;
  localparam logic [3:0] FMT_GIF     = 4'd3;
  localparam logic [3:0] FMT_FACE    = 4'd4;
  localparam logic [3:0] FMT_NASA    = 4'd5;
  localparam logic [3:0] FMT_UTAH    = 4'd6;
  localparam logic [3:0] FMT_SGI     = 4'd7;
  localparam logic [3:0] FMT_JPEG    = 4'd8;
  localparam logic [3:0] FMT_PCX     = 4'd9;
  localparam logic [3:0] FMT_UNKNOWN = 4'd10;

  typedef struct packed {
    logic shift_en;
    logic clear;
  } ifs_chain_ctl_t;

endpackage

// ===== sv/ifs_cell.sv =====
// One cell of the keyword window: holds a byte, compares its incoming byte to a tag.
// Depends on ifs_pkg for the control struct.
`timescale 1ns / 1ps
module ifs_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ifs_pkg::ifs_chain_ctl_t ctl,
  input  logic [7:0]             d,
  input  logic [7:0]             tag,
  output logic [7:0]             q,
  output logic                   hit
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      q_r <= 8'h00;
    end else if (ctl.shift_en) begin
      q_r <= d;
    end
  end

  // match on the value the cell takes this cycle
  assign hit = (d == tag);
  assign q   = q_r;

endmodule

// ===== sv/ifs_chain.sv =====
// Row of window cells that spots the RECORD_TYPE keyword in the byte stream.
// Depends on ifs_pkg and ifs_cell.
`timescale 1ns / 1ps
module ifs_chain (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ifs_pkg::ifs_chain_ctl_t ctl,
  input  logic [7:0]             data_byte,
  output logic                   kw_hit
);

  logic [7:0] cell_q   [ifs_pkg::REC_LEN];
  logic [7:0] cell_d   [ifs_pkg::REC_LEN];
  logic [ifs_pkg::REC_LEN-1:0] cell_hit;

  // newest byte enters the last cell, oldest sits in cell zero
  genvar gi;
  generate
    for (gi = 0; gi < ifs_pkg::REC_LEN; gi++) begin : g_cell
      if (gi == ifs_pkg::REC_LEN - 1) begin : g_in
        assign cell_d[gi] = data_byte;
      end else begin : g_mid
        assign cell_d[gi] = cell_q[gi+1];
      end
      ifs_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .d     (cell_d[gi]),
        .tag   (ifs_pkg::REC_TAG[gi]),
        .q     (cell_q[gi]),
        .hit   (cell_hit[gi])
      );
    end
  endgenerate

  assign kw_hit = ctl.shift_en && (&cell_hit);

endmodule

// ===== sv/image_format_sniffer_core.sv =====
// Image format sniffer: header bytes in, one format code per file out.
// Top level; uses ifs_pkg, ifs_chain and image_format_sniffer_core_macros.svh.
//
// Usage: send the header bytes of a file on the in_ channel, one byte per
// transaction, and mark the final byte with in_last_byte. Only the first
// HEADER_BYTES bytes are examined; later bytes are taken and ignored, but
// their last mark still closes the file. For every transaction with
// in_last_byte set, one transaction carrying out_format_code follows on the
// out_ channel; the code is held in out_format_code in the cycle after the
// last byte is accepted. All per-file state is cleared in the same edge, so
// the next file's first byte may follow at once. Throughput is one byte per
// cycle while in_stall is low: the keyword window is a row of eleven shifting
// cells and the other detectors are single-byte state machines.
// A stalled result sits in the output register; only a final byte is held
// back (in_stall) while an earlier result is still stalled, other bytes flow.
// Synchronous reset clears all per-file state and the output valid.
`include "image_format_sniffer_core_macros.svh"
`timescale 1ns / 1ps
module image_format_sniffer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_format_code
);

  localparam logic [1:0] BR_IDLE   = 2'd0;
  localparam logic [1:0] BR_KW     = 2'd1;
  localparam logic [1:0] BR_EQ     = 2'd2;
  localparam logic [1:0] BR_BLANKS = 2'd3;

  localparam logic [ifs_pkg::CNT_W-1:0] CNT_LIMIT =
    ifs_pkg::CNT_W'(ifs_pkg::HEADER_BYTES);

  logic                      in_acc;
  logic                      last_acc;
  logic                      take;
  ifs_pkg::ifs_chain_ctl_t   chain_ctl;
  logic                      kw_hit;

  logic [ifs_pkg::CNT_W-1:0] byte_count_r, byte_count_upd, byte_count_nxt;
  logic [7:0]                head_r   [ifs_pkg::HEAD_LEN];
  logic [7:0]                head_upd [ifs_pkg::HEAD_LEN];
  logic [7:0]                head_nxt [ifs_pkg::HEAD_LEN];
  logic [2:0]                line_pos_r, line_pos_upd, line_pos_nxt;
  logic                      line_start_r, line_start_upd, line_start_nxt;
  logic                      face_pend_r, face_pend_upd, face_pend_nxt;
  logic                      face_found_r, face_found_upd, face_found_nxt;
  logic [1:0]                blank_st_r, blank_st_upd, blank_st_nxt;
  logic                      nasa_found_r, nasa_found_upd, nasa_found_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [3:0]                out_code_r, out_code_nxt;
  logic [3:0]                verdict;

  // hold only a final byte while the previous result is stalled
  assign in_stall = out_valid_r && out_stall && in_last_byte;
  assign in_acc   = in_valid && !in_stall;
  assign last_acc = in_acc && in_last_byte;
  assign take     = in_acc && (byte_count_r < CNT_LIMIT);

  assign chain_ctl.shift_en = take;
  assign chain_ctl.clear    = last_acc;

  ifs_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (chain_ctl),
    .data_byte (in_data_byte),
    .kw_hit    (kw_hit)
  );

  // byte count and leading bytes
  always_comb begin
    byte_count_upd = byte_count_r;
    for (int i = 0; i < ifs_pkg::HEAD_LEN; i++) begin
      head_upd[i] = head_r[i];
    end
    if (take) begin
      byte_count_upd = byte_count_r + 1'b1;
      if (byte_count_r < ifs_pkg::CNT_W'(ifs_pkg::HEAD_LEN)) begin
        head_upd[byte_count_r[2:0]] = in_data_byte;
      end
    end
  end

  // face line detector
  always_comb begin
    line_pos_upd   = line_pos_r;
    line_start_upd = line_start_r;
    face_pend_upd  = face_pend_r;
    face_found_upd = face_found_r;
    if (take) begin
      if (face_pend_r) begin
        face_found_upd = 1'b1;
        face_pend_upd  = 1'b0;
        line_pos_upd   = 3'd0;
      end else if (line_pos_r != 3'd0 && in_data_byte == ifs_pkg::PIC_TAG[line_pos_r]) begin
        if (line_pos_r == 3'(ifs_pkg::PIC_LEN - 1)) begin
          face_pend_upd = 1'b1;
          line_pos_upd  = 3'd0;
        end else begin
          line_pos_upd = line_pos_r + 3'd1;
        end
      end else begin
        line_pos_upd = (line_start_r && in_data_byte == ifs_pkg::PIC_TAG[0]) ? 3'd1 : 3'd0;
      end
      line_start_upd = (in_data_byte == ifs_pkg::CH_NL);
    end
  end

  // keyword tail: blanks then '='
  always_comb begin
    blank_st_upd   = blank_st_r;
    nasa_found_upd = nasa_found_r;
    if (take) begin
      case (blank_st_r)
        BR_KW: begin
          blank_st_upd = (in_data_byte == ifs_pkg::CH_EQ)    ? BR_EQ :
                         (in_data_byte == ifs_pkg::CH_SPACE) ? BR_BLANKS : BR_IDLE;
        end
        BR_EQ: begin
          nasa_found_upd = 1'b1;
          blank_st_upd   = BR_IDLE;
        end
        BR_BLANKS: begin
          if (in_data_byte == ifs_pkg::CH_EQ) begin
            nasa_found_upd = 1'b1;
            blank_st_upd   = BR_IDLE;
          end else if (in_data_byte != ifs_pkg::CH_SPACE) begin
            blank_st_upd = BR_IDLE;
          end
        end
        default: begin
          blank_st_upd = BR_IDLE;
        end
      endcase
      if (kw_hit) begin
        blank_st_upd = BR_KW;
      end
    end
  end

  // verdict from the state after the final byte, in priority order
  always_comb begin
    if (byte_count_upd >= ifs_pkg::CNT_W'(2) &&
        ((head_upd[0] == 8'h4d && head_upd[1] == 8'h4d) ||
         (head_upd[0] == 8'h49 && head_upd[1] == 8'h49))) begin
      verdict = ifs_pkg::FMT_TIFF;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(5) &&
                 head_upd[0] == 8'h54 && head_upd[1] == 8'h59 && head_upd[2] == 8'h50 &&
                 head_upd[3] == 8'h45 && head_upd[4] == 8'h3d) begin
      verdict = ifs_pkg::FMT_PICFILE;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(7) &&
                 head_upd[0] == 8'h23 && head_upd[1] == 8'h64 && head_upd[2] == 8'h65 &&
                 head_upd[3] == 8'h66 && head_upd[4] == 8'h69 && head_upd[5] == 8'h6e &&
                 head_upd[6] == 8'h65) begin
      verdict = ifs_pkg::FMT_XBM;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(3) &&
                 head_upd[0] == 8'h47 && head_upd[1] == 8'h49 && head_upd[2] == 8'h46) begin
      verdict = ifs_pkg::FMT_GIF;
    end else if (face_found_upd) begin
      verdict = ifs_pkg::FMT_FACE;
    end else if (nasa_found_upd) begin
      verdict = ifs_pkg::FMT_NASA;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(2) &&
                 head_upd[0] == 8'h52 && head_upd[1] == 8'hcc) begin
      verdict = ifs_pkg::FMT_UTAH;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(2) &&
                 head_upd[0] == 8'h01 && head_upd[1] == 8'hda) begin
      verdict = ifs_pkg::FMT_SGI;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(2) &&
                 head_upd[0] == 8'hff && head_upd[1] == 8'hd8) begin
      verdict = ifs_pkg::FMT_JPEG;
    end else if (byte_count_upd >= ifs_pkg::CNT_W'(4) && head_upd[0] == 8'h0a &&
                 (head_upd[1] == 8'h00 || head_upd[1] == 8'h02 ||
                  head_upd[1] == 8'h03 || head_upd[1] == 8'h05) &&
                 head_upd[2] == 8'h01) begin
      verdict = ifs_pkg::FMT_PCX;
    end else begin
      verdict = ifs_pkg::FMT_UNKNOWN;
    end
  end

  // drop all per-file state once the verdict is taken
  always_comb begin
    byte_count_nxt = last_acc ? '0 : byte_count_upd;
    for (int i = 0; i < ifs_pkg::HEAD_LEN; i++) begin
      head_nxt[i] = last_acc ? 8'h00 : head_upd[i];
    end
    line_pos_nxt   = last_acc ? 3'd0 : line_pos_upd;
    line_start_nxt = last_acc ? 1'b1 : line_start_upd;
    face_pend_nxt  = last_acc ? 1'b0 : face_pend_upd;
    face_found_nxt = last_acc ? 1'b0 : face_found_upd;
    blank_st_nxt   = last_acc ? BR_IDLE : blank_st_upd;
    nasa_found_nxt = last_acc ? 1'b0 : nasa_found_upd;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    if (last_acc) begin
      out_valid_nxt = 1'b1;
      out_code_nxt  = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      line_pos_r   <= 3'd0;
      line_start_r <= 1'b1;
      face_pend_r  <= 1'b0;
      face_found_r <= 1'b0;
      blank_st_r   <= BR_IDLE;
      nasa_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < ifs_pkg::HEAD_LEN; i++) begin
        head_r[i] <= 8'h00;
      end
    end else begin
      byte_count_r <= byte_count_nxt;
      line_pos_r   <= line_pos_nxt;
      line_start_r <= line_start_nxt;
      face_pend_r  <= face_pend_nxt;
      face_found_r <= face_found_nxt;
      blank_st_r   <= blank_st_nxt;
      nasa_found_r <= nasa_found_nxt;
      out_valid_r  <= out_valid_nxt;
      for (int i = 0; i < ifs_pkg::HEAD_LEN; i++) begin
        head_r[i] <= head_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_format_code = out_code_r;

  `IFS_ASSERT(a_last_gives_result,
              (in_valid && !in_stall && in_last_byte) |=> out_valid,
              "final byte did not produce a result")
  `IFS_ASSERT(a_code_range,
              out_valid |-> (out_format_code <= ifs_pkg::FMT_UNKNOWN),
              "format code out of range")
  `IFS_ASSERT(a_state_cleared,
              (in_valid && !in_stall && in_last_byte) |=>
                (byte_count_r == '0 && !face_found_r && !nasa_found_r && line_start_r),
              "per-file state not cleared after verdict")
  `IFS_ASSERT_ALWAYS(a_pend_no_pos,
                     face_pend_r |-> (line_pos_r == 3'd0),
                     "face match pending with partial match position")

endmodule
